/* sv/tdr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package tdr_pkg;

  localparam int unsigned DETOUR_CAPACITY = 256;
  localparam int unsigned CAP_W           = (DETOUR_CAPACITY > 1) ? $clog2(DETOUR_CAPACITY) : 1;
  localparam int unsigned COUNT_W         = $clog2(DETOUR_CAPACITY + 1);

  localparam int unsigned TS_W      = 64;
  localparam int unsigned THRESH_W  = 32;
  localparam int unsigned TIMEOUT_W = 48;
  localparam int unsigned INDEX_W   = 8;
  localparam int unsigned OUT_CNT_W = 9;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 48;
  localparam int unsigned ENTRY_W   = 2 * TS_W;

  localparam int unsigned S_TDATA_W = TS_W + INDEX_W;
  localparam int unsigned M_FIELD_W = 1 + TS_W + OUT_CNT_W + 3 * TS_W + 1 + 3 * TS_W;
  localparam int unsigned M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 1'b1;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  localparam logic [THRESH_W-1:0]  THRESHOLD_RESET = 32'd3000;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET   = 48'd90000000000;

  typedef struct packed {
    logic [TS_W-1:0]      entry_duration;
    logic [TS_W-1:0]      entry_start;
    logic [TS_W-1:0]      elapsed;
    logic                 done_res;
    logic [TS_W-1:0]      max_delta;
    logic [TS_W-1:0]      min_delta;
    logic [TS_W-1:0]      noise_sum;
    logic [OUT_CNT_W-1:0] detour_count;
    logic [TS_W-1:0]      delta;
    logic                 detour_found;
  } result_t;

  typedef struct packed {
    logic [TS_W-1:0] duration;
    logic [TS_W-1:0] stamp;
  } entry_t;

endpackage
`default_nettype wire

/* sv/tdr_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module tdr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* sv/timestamp_detour_recorder_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// Detour recorder: takes one beat per clock unless back-pressure on m_tready fills both
// stages, mode in s_tuser picking a timestamp sample or a buffer read. The run state
// (start, previous time, count, noise sum, min and max gap) lives in flops and is updated
// once per sample, which sets the one-beat-per-clock rate; detours are written in order into a
// DETOUR_CAPACITY-entry RAM of time and length pairs with a registered read.
// Entries at or above the detour count read as zero, so no clearing pass follows reset.
// Results pass through a read stage and an output register; the read stage can still take
// a beat while a result waits at the output.
module timestamp_detour_recorder_top (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [tdr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tdr_pkg::CFG_W-1:0]      cfg_data,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [tdr_pkg::S_TDATA_W-1:0]  s_tdata,   // timestamp, entry_index
  input  wire logic                           s_tuser,   // mode
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // detour_found, delta, detour_count, noise_sum, min_delta, max_delta, done_res,
  // elapsed, entry_start, entry_duration, zero pad
  output logic      [tdr_pkg::M_TDATA_W-1:0]  m_tdata
);

  localparam int unsigned TS_W    = tdr_pkg::TS_W;
  localparam int unsigned COUNT_W = tdr_pkg::COUNT_W;
  localparam int unsigned CAP_W   = tdr_pkg::CAP_W;

  logic                          started, started_next;
  logic                          stopped, stopped_next;
  logic [TS_W-1:0]               start_time, start_time_next;
  logic [TS_W-1:0]               prev_time, prev_time_next;
  logic [COUNT_W-1:0]            count, count_next;
  logic [TS_W-1:0]               noise, noise_next;
  logic [TS_W-1:0]               min_gap, min_gap_next;
  logic [TS_W-1:0]               max_gap, max_gap_next;
  logic [tdr_pkg::THRESH_W-1:0]  threshold;
  logic [tdr_pkg::TIMEOUT_W-1:0] timeout;

  logic                          s_accept;
  logic                          is_sample;
  logic [TS_W-1:0]               ts;
  logic [tdr_pkg::INDEX_W-1:0]   entry_index;
  logic [TS_W-1:0]               elapsed_c, delta_c, delta_out, elapsed_out;
  logic                          found;
  logic                          ram_we;
  logic                          rd_valid;
  tdr_pkg::entry_t               wr_entry, rd_entry;

  logic                          s1_valid;
  logic                          s1_rd_valid;
  tdr_pkg::result_t              s1_res;
  tdr_pkg::result_t              out_res;
  logic                          out_free;

  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = !s1_valid || out_free;
  assign s_accept  = s_tvalid && s_tready;
  assign is_sample = (s_tuser == tdr_pkg::MODE_SAMPLE);
  assign ts          = s_tdata[TS_W-1:0];
  assign entry_index = s_tdata[TS_W +: tdr_pkg::INDEX_W];

  assign elapsed_c = ts - start_time;
  assign delta_c   = ts - prev_time;

  always_comb begin
    started_next    = started;
    stopped_next    = stopped;
    start_time_next = start_time;
    prev_time_next  = prev_time;
    count_next      = count;
    noise_next      = noise;
    min_gap_next    = min_gap;
    max_gap_next    = max_gap;
    found           = 1'b0;
    ram_we          = 1'b0;
    delta_out       = '0;
    elapsed_out     = '0;
    if (s_accept && is_sample) begin
      if (!started) begin
        started_next    = 1'b1;
        start_time_next = ts;
        prev_time_next  = ts;
        min_gap_next    = TS_W'(timeout);
        stopped_next    = (timeout == '0);
      end else begin
        elapsed_out = elapsed_c;
        if (!stopped) begin
          if (elapsed_c >= TS_W'(timeout)) begin
            stopped_next = 1'b1;
          end else begin
            delta_out      = delta_c;
            prev_time_next = ts;
            found = (delta_c > TS_W'(threshold)) &&
                    (count < COUNT_W'(tdr_pkg::DETOUR_CAPACITY));
            if (found) begin
              ram_we     = 1'b1;
              noise_next = noise + delta_c;
              count_next = count + 1'b1;
            end
            if (found && (count_next == COUNT_W'(tdr_pkg::DETOUR_CAPACITY))) begin
              stopped_next = 1'b1;
            end else begin
              if (delta_c < min_gap) begin
                min_gap_next = delta_c;
              end
              if (delta_c > max_gap) begin
                max_gap_next = delta_c;
              end
            end
          end
        end
      end
    end
    if (cfg_we && (cfg_index == tdr_pkg::REG_TIMEOUT) && !started) begin
      min_gap_next = TS_W'(cfg_data[tdr_pkg::TIMEOUT_W-1:0]);
    end
  end

  // an entry is valid only below the fill count
  assign rd_valid = (32'(entry_index) < tdr_pkg::DETOUR_CAPACITY) &&
                    (COUNT_W'(entry_index) < count);

  assign wr_entry.stamp    = ts;
  assign wr_entry.duration = delta_c;

  tdr_ram #(
    .WIDTH (tdr_pkg::ENTRY_W),
    .DEPTH (tdr_pkg::DETOUR_CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[CAP_W-1:0]),
    .wdata (wr_entry),
    .re    (s_accept && !is_sample),
    .raddr (CAP_W'(entry_index)),
    .rdata (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      started    <= 1'b0;
      stopped    <= 1'b0;
      start_time <= '0;
      prev_time  <= '0;
      count      <= '0;
      noise      <= '0;
      min_gap    <= TS_W'(tdr_pkg::TIMEOUT_RESET);
      max_gap    <= '0;
      threshold  <= tdr_pkg::THRESHOLD_RESET;
      timeout    <= tdr_pkg::TIMEOUT_RESET;
      s1_valid   <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      started    <= started_next;
      stopped    <= stopped_next;
      start_time <= start_time_next;
      prev_time  <= prev_time_next;
      count      <= count_next;
      noise      <= noise_next;
      min_gap    <= min_gap_next;
      max_gap    <= max_gap_next;
      if (cfg_we && (cfg_index == tdr_pkg::REG_THRESHOLD)) begin
        threshold <= cfg_data[tdr_pkg::THRESH_W-1:0];
      end
      if (cfg_we && (cfg_index == tdr_pkg::REG_TIMEOUT)) begin
        timeout <= cfg_data[tdr_pkg::TIMEOUT_W-1:0];
      end
      if (s_tready) begin
        s1_valid <= s_accept;
      end
      if (out_free) begin
        m_tvalid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_rd_valid         <= !is_sample && rd_valid;
      s1_res.detour_found <= found;
      s1_res.delta        <= delta_out;
      s1_res.detour_count <= tdr_pkg::OUT_CNT_W'(count_next);
      s1_res.noise_sum    <= noise_next;
      s1_res.min_delta    <= min_gap_next;
      s1_res.max_delta    <= max_gap_next;
      s1_res.done_res     <= stopped_next;
      s1_res.elapsed      <= elapsed_out;
      s1_res.entry_start    <= '0;
      s1_res.entry_duration <= '0;
    end
    if (out_free && s1_valid) begin
      if (s1_rd_valid) begin
        out_res <= {rd_entry, s1_res[tdr_pkg::M_FIELD_W-tdr_pkg::ENTRY_W-1:0]};
      end else begin
        out_res <= s1_res;
      end
    end
  end

  assign m_tdata = tdr_pkg::M_TDATA_W'(out_res);

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(tdr_pkg::DETOUR_CAPACITY))
    else $error("detour count beyond capacity");

  a_stop_sticky: assert property (@(posedge clk) disable iff (rst)
    stopped |=> stopped)
    else $error("stop flag cleared without reset");

  a_count_on_accept: assert property (@(posedge clk) disable iff (rst)
    !s_accept |=> $stable(count) && $stable(noise))
    else $error("detour state changed without an accepted beat");

  a_full_stops: assert property (@(posedge clk) disable iff (rst)
    (count == COUNT_W'(tdr_pkg::DETOUR_CAPACITY)) |-> stopped)
    else $error("buffer full but recorder running");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_free |=> s1_valid && $stable(s1_res))
    else $error("read stage lost a stalled beat");

endmodule
`default_nettype wire
